[hdl/binary_pair_covariance_engine_macros.svh]
// ----------------------------------------------------------------------------
// Binary pair covariance engine assertion macros
// Shared concurrent assertion forms for the engine's checker.
// ----------------------------------------------------------------------------
`ifndef BINARY_PAIR_COVARIANCE_ENGINE_MACROS_SVH
`define BINARY_PAIR_COVARIANCE_ENGINE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define BPCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define BPCE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hdl/bpce_pkg.sv]
// ----------------------------------------------------------------------------
// Binary pair covariance engine package
// Field widths, codes and controller interface types.
// ----------------------------------------------------------------------------
package bpce_pkg;

  localparam int unsigned MaxVarsDefault = 8;
  localparam int unsigned WeightW        = 32;
  localparam int unsigned IndexW         = 8;
  localparam int unsigned PairW          = 6;
  localparam int unsigned CovW           = 36;
  localparam int unsigned VarsW          = 4;
  localparam int unsigned DivSteps       = 6;
  localparam int unsigned PaddrW         = 3;
  localparam int unsigned ApbDataW       = 32;
  localparam int unsigned RegIdxLsb      = 2;

  localparam logic [VarsW-1:0] NumVarsReset    = 4'd8;
  localparam logic             ScalePairsReset = 1'b1;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic RegNumVars    = 1'b0;
  localparam logic RegScalePairs = 1'b1;

  typedef struct packed {
    logic load_wr;
    logic clr_wr;
    logic capture;
    logic div_step;
    logic walk_start;
    logic walk_rd;
    logic clip_en;
    logic mul_en;
    logic res_load;
    logic res_zero;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic walk_last;
    logic pair_bad;
    logic out_free;
  } ctrl_stat_t;

endpackage

[hdl/bpce_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpce_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/bpce_ctrl.sv]
// ----------------------------------------------------------------------------
// Binary pair covariance engine controller
// Sequences memory clearing, loads, pair division, the weight walk and the
// result stages.
// ----------------------------------------------------------------------------
module bpce_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  op_i,
  output logic                  in_stall_o,
  input  bpce_pkg::ctrl_stat_t  stat_i,
  output bpce_pkg::ctrl_cmd_t   cmd_o
);

  import bpce_pkg::*;

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StDiv   = 4'd2;
  localparam logic [3:0] StWalk  = 4'd3;
  localparam logic [3:0] StDrain = 4'd4;
  localparam logic [3:0] StClip  = 4'd5;
  localparam logic [3:0] StMul   = 4'd6;
  localparam logic [3:0] StDone  = 4'd7;
  localparam logic [3:0] StZero  = 4'd8;

  localparam int unsigned CntW = $clog2(DivSteps);

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (op_i == OpQuery) begin
            cmd_o.capture = 1'b1;
            cnt_d         = '0;
            state_d       = StDiv;
          end else begin
            cmd_o.load_wr = 1'b1;
          end
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          if (stat_i.pair_bad) begin
            state_d = StZero;
          end else begin
            cmd_o.walk_start = 1'b1;
            state_d          = StWalk;
          end
        end
      end
      StWalk: begin
        cmd_o.walk_rd = 1'b1;
        if (stat_i.walk_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StClip;
      end
      StClip: begin
        cmd_o.clip_en = 1'b1;
        state_d       = StMul;
      end
      StMul: begin
        cmd_o.mul_en = 1'b1;
        state_d      = StDone;
      end
      StDone: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = StIdle;
        end
      end
      StZero: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_zero = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[hdl/bpce_dpath.sv]
// ----------------------------------------------------------------------------
// Binary pair covariance engine datapath
// Weight memory, pair index divider, masked sum accumulators, clipping,
// product, scaling and the output register.
// ----------------------------------------------------------------------------
module bpce_dpath #(
  parameter int unsigned MAX_VARS = bpce_pkg::MaxVarsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bpce_pkg::ctrl_cmd_t                  cmd_i,
  output bpce_pkg::ctrl_stat_t                 stat_o,
  input  logic [bpce_pkg::VarsW-1:0]           num_vars_i,
  input  logic                                 scale_pairs_i,
  input  logic [bpce_pkg::IndexW-1:0]          weight_index_i,
  input  logic [bpce_pkg::WeightW-1:0]         weight_value_i,
  input  logic [bpce_pkg::PairW-1:0]           first_pair_i,
  input  logic [bpce_pkg::PairW-1:0]           second_pair_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [bpce_pkg::CovW-1:0]     covariance_o,
  output logic                                 saturated_o
);

  import bpce_pkg::*;

  localparam int unsigned AddrW = MAX_VARS;
  localparam int unsigned Depth = 1 << MAX_VARS;
  localparam int unsigned AccW  = WeightW + MAX_VARS;

  logic [VarsW-1:0]     p;
  logic [2*VarsW-1:0]   pp;

  logic [PairW-1:0]     da_q, db_q, qa_q, qb_q;
  logic [VarsW-1:0]     ra_q, rb_q;
  logic [VarsW:0]       ta, tb;
  logic                 gea, geb;
  logic                 bad_q;

  logic [MAX_VARS-1:0]  mij, mkl;
  logic                 dif_ij, dif_kl;

  logic [AddrW-1:0]     s_q, s_d1_q, last_s;
  logic                 rv_q;
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  logic [WeightW-1:0]   ram_wdata, rdata;
  logic                 hij, hkl;

  logic [AccW-1:0]      eij_q, ekl_q, eijkl_q;
  logic [WeightW-1:0]   cij_q, ckl_q, cijkl_q;
  logic                 sat_clip_q;
  logic [2*WeightW-1:0] prod_full;
  logic [WeightW-1:0]   prod_q;
  logic [CovW-1:0]      diff, shifted;
  logic [1:0]           shamt;

  logic                 out_valid_q, sat_q;
  logic [CovW-1:0]      cov_q;

  // Active variable count, forced into 1..MAX_VARS.
  always_comb begin
    if (num_vars_i == '0) begin
      p = VarsW'(1);
    end else if (num_vars_i > VarsW'(MAX_VARS)) begin
      p = VarsW'(MAX_VARS);
    end else begin
      p = num_vars_i;
    end
  end

  assign pp              = (2*VarsW)'(p) * (2*VarsW)'(p);
  assign stat_o.pair_bad = bad_q;

  // Restoring division of both pair codes by p, one quotient bit per step.
  assign ta  = {ra_q, da_q[PairW-1]};
  assign tb  = {rb_q, db_q[PairW-1]};
  assign gea = ta >= {1'b0, p};
  assign geb = tb >= {1'b0, p};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      da_q  <= first_pair_i;
      db_q  <= second_pair_i;
      qa_q  <= '0;
      qb_q  <= '0;
      ra_q  <= '0;
      rb_q  <= '0;
      bad_q <= ((2*VarsW)'(first_pair_i) >= pp) || ((2*VarsW)'(second_pair_i) >= pp);
    end else if (cmd_i.div_step) begin
      da_q <= {da_q[PairW-2:0], 1'b0};
      db_q <= {db_q[PairW-2:0], 1'b0};
      qa_q <= {qa_q[PairW-2:0], gea};
      qb_q <= {qb_q[PairW-2:0], geb};
      ra_q <= gea ? VarsW'(ta - {1'b0, p}) : VarsW'(ta);
      rb_q <= geb ? VarsW'(tb - {1'b0, p}) : VarsW'(tb);
    end
  end

  assign mij    = (MAX_VARS'(1) << qa_q[VarsW-1:0]) | (MAX_VARS'(1) << ra_q);
  assign mkl    = (MAX_VARS'(1) << qb_q[VarsW-1:0]) | (MAX_VARS'(1) << rb_q);
  assign dif_ij = qa_q[VarsW-1:0] != ra_q;
  assign dif_kl = qb_q[VarsW-1:0] != rb_q;

  // Shared state counter for the clearing pass and the query walk.
  assign last_s           = ~({AddrW{1'b1}} << p);
  assign stat_o.walk_last = s_q == last_s;
  assign stat_o.clr_last  = &s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q  <= '0;
      rv_q <= 1'b0;
    end else begin
      rv_q <= cmd_i.walk_rd;
      if (cmd_i.walk_start) begin
        s_q <= '0;
      end else if (cmd_i.walk_rd || cmd_i.clr_wr) begin
        s_q <= s_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_d1_q <= s_q;
  end

  assign ram_we    = cmd_i.load_wr || cmd_i.clr_wr;
  assign ram_waddr = cmd_i.clr_wr ? s_q : AddrW'(weight_index_i);
  assign ram_wdata = cmd_i.clr_wr ? '0 : weight_value_i;

  bpce_ram #(
    .Width (WeightW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (s_q),
    .rdata_o (rdata)
  );

  assign hij = (s_d1_q & mij) == mij;
  assign hkl = (s_d1_q & mkl) == mkl;

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      eij_q   <= '0;
      ekl_q   <= '0;
      eijkl_q <= '0;
    end else if (rv_q) begin
      if (hij) begin
        eij_q <= eij_q + AccW'(rdata);
      end
      if (hkl) begin
        ekl_q <= ekl_q + AccW'(rdata);
      end
      if (hij && hkl) begin
        eijkl_q <= eijkl_q + AccW'(rdata);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clip_en) begin
      cij_q      <= (|eij_q[AccW-1:WeightW])   ? '1 : eij_q[WeightW-1:0];
      ckl_q      <= (|ekl_q[AccW-1:WeightW])   ? '1 : ekl_q[WeightW-1:0];
      cijkl_q    <= (|eijkl_q[AccW-1:WeightW]) ? '1 : eijkl_q[WeightW-1:0];
      sat_clip_q <= (|eij_q[AccW-1:WeightW]) || (|ekl_q[AccW-1:WeightW]) ||
                    (|eijkl_q[AccW-1:WeightW]);
    end
  end

  assign prod_full = cij_q * ckl_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_full[2*WeightW-1:WeightW];
    end
  end

  assign diff    = CovW'(cijkl_q) - CovW'(prod_q);
  assign shamt   = {1'b0, scale_pairs_i && dif_ij} + {1'b0, scale_pairs_i && dif_kl};
  assign shifted = diff << shamt;

  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      cov_q <= cmd_i.res_zero ? '0 : shifted;
      sat_q <= cmd_i.res_zero ? 1'b0 : sat_clip_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign covariance_o = $signed(cov_q);
  assign saturated_o  = sat_q;

endmodule

[hdl/binary_pair_covariance_engine.sv]
// ----------------------------------------------------------------------------
// Binary pair covariance engine
// Holds one probability weight per binary state and returns the scaled
// covariance of two variable pairs over that distribution.
//
//   Channel   Handshake             Payload
//   input     in_valid_i/in_stall_o op, weight_index, weight_value, pairs
//   output    out_valid_o/out_stall_i covariance, saturated
//   config    psel/penable/pready   paddr, pwdata, prdata
//
// After reset the weight memory is cleared, one entry per cycle, over all
// 2^MAX_VARS entries; the input stalls meanwhile.
// A load keeps the input open. A query stalls the input through the
// division, the walk over the weight memory's single read port and the
// result stages; a pair code at or above p*p gives zero after the division.
// The output register holds a result while out_stall_i is high, and loads
// are still taken meanwhile.
// ----------------------------------------------------------------------------
module binary_pair_covariance_engine #(
  parameter int unsigned MAX_VARS = bpce_pkg::MaxVarsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 op_i,
  input  logic [bpce_pkg::IndexW-1:0]          weight_index_i,
  input  logic [bpce_pkg::WeightW-1:0]         weight_value_i,
  input  logic [bpce_pkg::PairW-1:0]           first_pair_i,
  input  logic [bpce_pkg::PairW-1:0]           second_pair_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [bpce_pkg::CovW-1:0]     covariance_o,
  output logic                                 saturated_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bpce_pkg::PaddrW-1:0]          paddr,
  input  logic [bpce_pkg::ApbDataW-1:0]        pwdata,
  output logic [bpce_pkg::ApbDataW-1:0]        prdata,
  output logic                                 pready
);

  import bpce_pkg::*;

  logic             num_vars_wr;
  logic             cfg_wr;
  logic [VarsW-1:0] num_vars_q;
  logic             scale_pairs_q;
  ctrl_cmd_t        cmd;
  ctrl_stat_t       stat;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign num_vars_wr = paddr[RegIdxLsb] == RegNumVars;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vars_q    <= NumVarsReset;
      scale_pairs_q <= ScalePairsReset;
    end else if (cfg_wr) begin
      if (num_vars_wr) begin
        num_vars_q <= pwdata[VarsW-1:0];
      end else begin
        scale_pairs_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    unique case (paddr[RegIdxLsb])
      RegNumVars:    prdata = ApbDataW'(num_vars_q);
      RegScalePairs: prdata = ApbDataW'(scale_pairs_q);
      default:       prdata = '0;
    endcase
  end

  bpce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bpce_dpath #(
    .MAX_VARS (MAX_VARS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .num_vars_i     (num_vars_q),
    .scale_pairs_i  (scale_pairs_q),
    .weight_index_i (weight_index_i),
    .weight_value_i (weight_value_i),
    .first_pair_i   (first_pair_i),
    .second_pair_i  (second_pair_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .covariance_o   (covariance_o),
    .saturated_o    (saturated_o)
  );

endmodule

[hdl/bpce_checker.sv]
// ----------------------------------------------------------------------------
// Binary pair covariance engine checker
// Port-level assertions on transaction sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_pair_covariance_engine_macros.svh"

module bpce_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic op_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic pready
);

  import bpce_pkg::*;

  `BPCE_ASSERT_NEXT(a_query_blocks_input, clk_i, rst_ni, in_valid_i && !in_stall_o && op_i == OpQuery, in_stall_o, "Input not stalled after a query transaction.")
  `BPCE_ASSERT_NEXT(a_load_keeps_input_open, clk_i, rst_ni, in_valid_i && !in_stall_o && op_i == OpLoad, !in_stall_o, "Input stalled after a load transaction.")
  `BPCE_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "Result dropped while stalled.")
  `BPCE_ASSERT_SAME(a_pready_high, clk_i, rst_ni, 1'b1, pready, "Configuration port not ready.")

endmodule

bind binary_pair_covariance_engine bpce_checker u_bpce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pready      (pready)
);
